### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the motor drive fault guard.
// Plain text macros, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond at one edge implies res at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

### hw/rtl/mdfp_pkg.sv
// Types, codes and compare helpers for the motor drive fault guard.
// No dependencies.
package mdfp_pkg;

  // Near-limit samples tolerated before the near over-current fault trips
  localparam int unsigned NEAR_TRIP_COUNT = 10;

  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATED_VOLTAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_BAND  = 2'd2;

  // Fault register bit positions
  localparam int unsigned FLT_NEAR_OC  = 0;
  localparam int unsigned FLT_OVER_OC  = 1;
  localparam int unsigned FLT_OVER_V   = 2;
  localparam int unsigned FLT_UNDER_V  = 3;

  typedef enum logic [2:0] {
    ACT_CURRENT_SAMPLE = 3'd0,
    ACT_VOLTAGE_SAMPLE = 3'd1,
    ACT_GATE_EVAL      = 3'd2,
    ACT_RUN_REQUEST    = 3'd3,
    ACT_CLEAR_FAULTS   = 3'd4
  } action_e;

  typedef struct packed {
    logic [14:0] current_limit;
    logic [15:0] rated_voltage;
    logic [15:0] voltage_band;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] phase_a;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_c;
    logic [15:0]        bus_voltage;
    logic               break_ready;
  } item_t;

  typedef struct packed {
    logic       stop;
    logic       brake;
    logic [3:0] fault;
    logic [3:0] near_cnt;
  } state_t;

  typedef struct packed {
    logic       stop_latched;
    logic       brake_active;
    logic [3:0] fault_bits;
    logic       brake_pulse;
    logic       restore_pulse;
  } result_t;

  // Exact nine-tenths test: 10*i > 9*lim or -10*i > 9*lim
  function automatic logic is_near(logic signed [15:0] i, logic [14:0] lim);
    logic signed [21:0] m;
    logic [18:0]        l9u;
    logic signed [21:0] l9;
    m   = (22'(i) <<< 3) + (22'(i) <<< 1);
    l9u = ({4'b0000, lim} << 3) + {4'b0000, lim};
    l9  = $signed({3'b000, l9u});
    return (m > l9) || (m < -l9);
  endfunction

  // Strict trip test: i > lim or i < -lim
  function automatic logic is_over(logic signed [15:0] i, logic [14:0] lim);
    logic signed [16:0] iv;
    logic signed [16:0] lv;
    iv = 17'(i);
    lv = $signed({2'b00, lim});
    return (iv > lv) || (iv < -lv);
  endfunction

endpackage

### hw/rtl/mdfp_cfg.sv
// Configuration register file of the motor drive fault guard.
// Depends on mdfp_pkg.
module mdfp_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mdfp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  output mdfp_pkg::cfg_t                   cfg_o
);
  import mdfp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; an index past the list is dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CURRENT_LIMIT: cfg_d.current_limit = cfg_data_i[14:0];
        CFG_RATED_VOLTAGE: cfg_d.rated_voltage = cfg_data_i;
        CFG_VOLTAGE_BAND:  cfg_d.voltage_band  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_limit <= 15'h7FFF;
      cfg_q.rated_voltage <= 16'h8000;
      cfg_q.voltage_band  <= 16'h1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/mdfp_eval.sv
// Single-pass evaluation of one item against the protection state.
// Depends on mdfp_pkg.
module mdfp_eval (
  input  mdfp_pkg::item_t   item_i,
  input  mdfp_pkg::state_t  state_i,
  input  mdfp_pkg::cfg_t    cfg_i,
  output mdfp_pkg::state_t  state_o,
  output mdfp_pkg::result_t result_o
);
  import mdfp_pkg::*;

  logic        near_any;
  logic        over_any;
  logic [4:0]  cnt_inc;
  logic [16:0] v_high;
  logic [16:0] v_sum;
  state_t      st;
  logic        brake_pulse;
  logic        restore_pulse;

  // Phase compares against the trip level and nine tenths of it
  assign near_any = is_near(item_i.phase_a, cfg_i.current_limit)
                  | is_near(item_i.phase_b, cfg_i.current_limit)
                  | is_near(item_i.phase_c, cfg_i.current_limit);
  assign over_any = is_over(item_i.phase_a, cfg_i.current_limit)
                  | is_over(item_i.phase_b, cfg_i.current_limit)
                  | is_over(item_i.phase_c, cfg_i.current_limit);
  assign cnt_inc  = {1'b0, state_i.near_cnt} + 5'd1;

  // Bus window: u > rated + band, and u < rated - band as u + band < rated
  assign v_high = {1'b0, cfg_i.rated_voltage} + {1'b0, cfg_i.voltage_band};
  assign v_sum  = {1'b0, item_i.bus_voltage} + {1'b0, cfg_i.voltage_band};

  always_comb begin
    st            = state_i;
    brake_pulse   = 1'b0;
    restore_pulse = 1'b0;
    unique case (action_e'(item_i.action))
      ACT_CURRENT_SAMPLE: begin
        if (near_any) begin
          if (cnt_inc > 5'(NEAR_TRIP_COUNT)) begin
            st.stop             = 1'b1;
            st.fault[FLT_NEAR_OC] = 1'b1;
            st.near_cnt         = '0;
          end else begin
            st.near_cnt = cnt_inc[3:0];
          end
        end
        if (over_any) begin
          st.stop               = 1'b1;
          st.fault[FLT_OVER_OC] = 1'b1;
        end
      end
      ACT_VOLTAGE_SAMPLE: begin
        if ({1'b0, item_i.bus_voltage} > v_high) begin
          st.stop              = 1'b1;
          st.fault[FLT_OVER_V] = 1'b1;
        end
        if (v_sum < {1'b0, cfg_i.rated_voltage}) begin
          st.stop               = 1'b1;
          st.fault[FLT_UNDER_V] = 1'b1;
        end
      end
      ACT_GATE_EVAL: begin
        // A standing stop or fault forces stop and brake; else release on break-ready, else stop
        if (st.stop || (st.fault != '0)) begin
          st.stop     = 1'b1;
          st.brake    = 1'b1;
          brake_pulse = 1'b1;
        end else if (item_i.break_ready) begin
          st.brake      = 1'b0;
          restore_pulse = 1'b1;
        end else begin
          st.stop = 1'b1;
        end
      end
      ACT_RUN_REQUEST:  st.stop  = 1'b0;
      ACT_CLEAR_FAULTS: st.fault = '0;
      default: ;
    endcase
  end

  assign state_o                = st;
  assign result_o.stop_latched  = st.stop;
  assign result_o.brake_active  = st.brake;
  assign result_o.fault_bits    = st.fault;
  assign result_o.brake_pulse   = brake_pulse;
  assign result_o.restore_pulse = restore_pulse;

endmodule

### hw/rtl/motor_drive_fault_protection.sv
// Top level of the motor drive fault guard: input register, state, result register.
// Depends on mdfp_pkg, mdfp_cfg, mdfp_eval and assert_macros.svh.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------------
//   input   | in        | in_valid_i / in_ready_o    | action, three phase currents,
//           |           |                            | bus voltage, break-ready level
//   result  | out       | out_valid_o / out_ready_i  | stop, brake, fault bits, pulses
//   config  | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while results are taken; out_valid_o rises once the beat
// has passed through the input register, then evaluation into the result register,
// which also updates state.
// Reset puts the guard in stop, brake released, no faults, near-limit count zero,
// and loads the default limits; no clearing pass is needed.
// A stalled result holds the input register; input ready drops only when both are full.
// Config writes are taken in any cycle.
`include "assert_macros.svh"

module motor_drive_fault_protection (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     action_i,
  input  logic signed [15:0]             phase_a_current_i,
  input  logic signed [15:0]             phase_b_current_i,
  input  logic signed [15:0]             phase_c_current_i,
  input  logic [15:0]                    bus_voltage_i,
  input  logic                           break_input_ready_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           stop_latched_o,
  output logic                           brake_active_o,
  output logic [3:0]                     fault_bits_o,
  output logic                           brake_pulse_o,
  output logic                           output_restore_pulse_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mdfp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import mdfp_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    res_valid_q;
  logic    advance;

  mdfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mdfp_eval u_eval (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Move the held beat into the result register when that slot frees up
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action      <= action_i;
      item_q.phase_a     <= phase_a_current_i;
      item_q.phase_b     <= phase_b_current_i;
      item_q.phase_c     <= phase_c_current_i;
      item_q.bus_voltage <= bus_voltage_i;
      item_q.break_ready <= break_input_ready_i;
    end
  end

  // Protection state, updated as each beat is evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stop     <= 1'b1;
      state_q.brake    <= 1'b0;
      state_q.fault    <= '0;
      state_q.near_cnt <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = res_valid_q;
  assign stop_latched_o         = res_q.stop_latched;
  assign brake_active_o         = res_q.brake_active;
  assign fault_bits_o           = res_q.fault_bits;
  assign brake_pulse_o          = res_q.brake_pulse;
  assign output_restore_pulse_o = res_q.restore_pulse;

  // Faults only drop on a clear-faults beat
  `ASSERT_NEXT(a_fault_sticky, clk_i, rst_ni, advance && (item_q.action != ACT_CLEAR_FAULTS), (state_q.fault & $past(state_q.fault)) == $past(state_q.fault), "fault bit dropped without clear")
  // A stalled result keeps the next beat in the input register
  `ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, item_valid_q && res_valid_q && !out_ready_i, item_valid_q && $stable(item_q), "input beat lost under stall")
  // Near-limit count stays within the trip threshold
  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, state_q.near_cnt <= 4'(NEAR_TRIP_COUNT), "near-limit count out of range")
  // A restore leaves the drive running with the brake released
  `ASSERT_CLK(a_restore_state, clk_i, rst_ni, !(out_valid_o && output_restore_pulse_o) || (!stop_latched_o && !brake_active_o && !brake_pulse_o), "restore pulse with stop or brake")

endmodule
